/* hdl/dtc_pkg.sv */
// shared types, constants and helpers for the divider/timer/counter block
package dtc_pkg;

   localparam int unsigned DIV_WIDTH     = 16;
   localparam int unsigned CNT_WIDTH     = 8;
   localparam int unsigned CTRL_WIDTH    = 3;
   localparam int unsigned CD_WIDTH      = 3;
   localparam int unsigned DATA_WIDTH    = 8;
   localparam int unsigned TYPE_WIDTH    = 2;
   localparam int unsigned INDEX_WIDTH   = 2;
   localparam int unsigned SEL_WIDTH     = 4;

   localparam bit          SKIP_BOOT_DEFAULT = 1'b0;
   localparam logic [DIV_WIDTH-1:0]  BOOT_DIVIDER  = 16'hABCC;
   localparam logic [CD_WIDTH-1:0]   RELOAD_TICKS  = 3'd4;
   localparam logic [DATA_WIDTH-1:0] CTRL_READ_SET = 8'hF8;
   localparam int unsigned           APU_BIT       = 4;

   // divider bit used as timer clock for each rate select code
   localparam logic [SEL_WIDTH-1:0] CLOCK_BIT_SEL [4] = '{4'd9, 4'd3, 4'd5, 4'd7};

   typedef enum logic [TYPE_WIDTH-1:0] {
      REQ_TICK  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } req_kind_type;

   typedef enum logic [INDEX_WIDTH-1:0] {
      REG_DIV    = 2'd0,
      REG_CNT    = 2'd1,
      REG_RELOAD = 2'd2,
      REG_CTRL   = 2'd3
   } reg_sel_type;

   typedef struct packed {
      logic [TYPE_WIDTH-1:0]  req_type;
      logic [INDEX_WIDTH-1:0] reg_index;
      logic [DATA_WIDTH-1:0]  write_data;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  timer_irq;
      logic                  apu_div_step;
   } rsp_payload_type;

   // enabled, selected divider bit
   function automatic logic timer_clock(input logic [CTRL_WIDTH-1:0] ctrl,
                                        input logic [DIV_WIDTH-1:0]  div);
      return ctrl[2] & div[CLOCK_BIT_SEL[ctrl[1:0]]];
   endfunction

endpackage

/* hdl/dtc_if.sv */
// request and response channel interfaces
interface dtc_req_if import dtc_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [TYPE_WIDTH-1:0]  req_type;
   logic [INDEX_WIDTH-1:0] reg_index;
   logic [DATA_WIDTH-1:0]  write_data;

   modport source (output valid, output req_type, output reg_index, output write_data,
                   input ready);
   modport sink   (input valid, input req_type, input reg_index, input write_data,
                   output ready);
endinterface

interface dtc_rsp_if import dtc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] read_data;
   logic                  timer_irq;
   logic                  apu_div_step;

   modport source (output valid, output read_data, output timer_irq, output apu_div_step,
                   input ready);
   modport sink   (input valid, input read_data, input timer_irq, input apu_div_step,
                   output ready);
endinterface

/* hdl/divider_timer_counter_unit.sv */
// top level of the divider/timer/counter block
//
// usage:
//  - req_if carries one request per handshake: a machine tick, a register read or a
//    register write (reg_index selects divider, counter, reload value or control)
//  - rsp_if returns exactly one response per request, in order: read_data on reads,
//    timer_irq when a delayed counter reload lands, apu_div_step when a tick makes divider bit 4 fall
//  - responses are registered: a response is written into the output register, or into
//    the skid entry while the output register is held, at the edge that accepts its request
//  - throughput: one request per clock, sustained, as long as responses are taken
//  - the timer state updates in the same cycle the request is accepted; the response
//    goes to an output register backed by a skid entry
//  - when the receiver stalls, one more request is still taken into the skid entry,
//    then req_if.ready drops until the output register drains
//  - reset (synchronous) clears all timer state; divider comes up at zero, or at the
//    post-boot value when SKIP_BOOT is set; both response entries are emptied
module divider_timer_counter_unit import dtc_pkg::*; #(
   parameter bit SKIP_BOOT = SKIP_BOOT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dtc_req_if.sink    req_if,
   dtc_rsp_if.source  rsp_if
);

   logic            req_step;     // request accepted this cycle
   logic            buf_space;    // skid entry free
   req_payload_type req_payload;
   rsp_payload_type step_result;  // response computed for the accepted request
   rsp_payload_type rsp_payload;

   // gather request fields
   assign req_payload.req_type   = req_if.req_type;
   assign req_payload.reg_index  = req_if.reg_index;
   assign req_payload.write_data = req_if.write_data;

   // accept whenever the response buffer can hold one more
   assign req_if.ready = buf_space;
   assign req_step     = req_if.valid & buf_space;

   // timer state and request update
   dtc_core #(
      .SKIP_BOOT (SKIP_BOOT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (req_step),
      .req    (req_payload),
      .result (step_result)
   );

   // response register with skid
   dtc_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (req_step),
      .push_data  (step_result),
      .space      (buf_space),
      .head_valid (rsp_if.valid),
      .head_ready (rsp_if.ready),
      .head_data  (rsp_payload)
   );

   // drive response fields
   assign rsp_if.read_data    = rsp_payload.read_data;
   assign rsp_if.timer_irq    = rsp_payload.timer_irq;
   assign rsp_if.apu_div_step = rsp_payload.apu_div_step;

endmodule

/* hdl/dtc_core.sv */
// timer state registers and the per-request update logic
module dtc_core import dtc_pkg::*; #(
   parameter bit SKIP_BOOT = SKIP_BOOT_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type req,
   output rsp_payload_type result
);

   logic [DIV_WIDTH-1:0]  divider_ff, divider_in;
   logic [CNT_WIDTH-1:0]  counter_ff, counter_in;
   logic [CNT_WIDTH-1:0]  reload_ff, reload_in;
   logic [CTRL_WIDTH-1:0] control_ff, control_in;
   logic [CD_WIDTH-1:0]   countdown_ff, countdown_in;
   logic                  reloaded_ff, reloaded_in;
   logic                  last_edge_ff, last_edge_in;

   logic                  do_edge;
   logic                  edge_now;
   logic [CNT_WIDTH-1:0]  cnt_mid;
   logic [CD_WIDTH-1:0]   cd_mid;
   logic [CD_WIDTH-1:0]   cd_dec;

   always_comb begin
      divider_in  = divider_ff;
      reload_in   = reload_ff;
      control_in  = control_ff;
      reloaded_in = reloaded_ff;
      cnt_mid     = counter_ff;
      cd_mid      = countdown_ff;
      cd_dec      = countdown_ff - 3'd1;
      do_edge     = 1'b0;
      result      = '0;
      case (req_kind_type'(req.req_type))
         REQ_TICK: begin
            reloaded_in = 1'b0;
            if (countdown_ff != '0) begin
               cd_mid = cd_dec;
               if (cd_dec == '0) begin
                  cnt_mid          = reload_ff;
                  result.timer_irq = 1'b1;
                  reloaded_in      = 1'b1;
               end
            end
            divider_in          = divider_ff + 16'd1;
            result.apu_div_step = divider_ff[APU_BIT] & ~divider_in[APU_BIT];
            do_edge             = 1'b1;
         end
         REQ_READ: begin
            case (reg_sel_type'(req.reg_index))
               REG_DIV:    result.read_data = divider_ff[DIV_WIDTH-1 -: DATA_WIDTH];
               REG_CNT:    result.read_data = counter_ff;
               REG_RELOAD: result.read_data = reload_ff;
               REG_CTRL:   result.read_data = CTRL_READ_SET | DATA_WIDTH'(control_ff);
               default:    result.read_data = '0;
            endcase
         end
         REQ_WRITE: begin
            case (reg_sel_type'(req.reg_index))
               REG_DIV: begin
                  divider_in = '0;
                  do_edge    = 1'b1;
               end
               REG_CNT: begin
                  // ignored after the tick on which the reload landed, until the next tick
                  if (!reloaded_ff) begin
                     cd_mid  = '0;
                     cnt_mid = req.write_data;
                  end
               end
               REG_RELOAD: begin
                  reload_in = req.write_data;
                  if (reloaded_ff) begin
                     cnt_mid = req.write_data;
                  end
               end
               REG_CTRL: begin
                  control_in = req.write_data[CTRL_WIDTH-1:0];
                  do_edge    = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      // falling edge of the timer clock bumps the counter; overflow to zero starts the reload countdown
      edge_now     = timer_clock(control_in, divider_in);
      counter_in   = cnt_mid;
      countdown_in = cd_mid;
      last_edge_in = last_edge_ff;
      if (do_edge) begin
         last_edge_in = edge_now;
         if (last_edge_ff && !edge_now) begin
            counter_in = cnt_mid + 8'd1;
            if (counter_in == '0) begin
               countdown_in = RELOAD_TICKS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff   <= SKIP_BOOT ? BOOT_DIVIDER : '0;
         counter_ff   <= '0;
         reload_ff    <= '0;
         control_ff   <= '0;
         countdown_ff <= '0;
         reloaded_ff  <= 1'b0;
         last_edge_ff <= 1'b0;
      end else if (step) begin
         divider_ff   <= divider_in;
         counter_ff   <= counter_in;
         reload_ff    <= reload_in;
         control_ff   <= control_in;
         countdown_ff <= countdown_in;
         reloaded_ff  <= reloaded_in;
         last_edge_ff <= last_edge_in;
      end
   end

   a_countdown_range: assert property (@(posedge clock) disable iff (reset)
      countdown_ff <= RELOAD_TICKS)
      else $error("reload countdown out of range");

   a_div_tick: assert property (@(posedge clock) disable iff (reset)
      step && req.req_type == REQ_TICK |=> divider_ff == $past(divider_ff) + 16'd1)
      else $error("divider did not advance on tick");

   a_irq_source: assert property (@(posedge clock) disable iff (reset)
      step && result.timer_irq |-> countdown_ff == 3'd1 && req.req_type == REQ_TICK)
      else $error("timer irq without pending reload");

   a_cnt_write: assert property (@(posedge clock) disable iff (reset)
      step && req.req_type == REQ_WRITE && req.reg_index == REG_CNT && !reloaded_ff
      |=> countdown_ff == '0 && counter_ff == $past(req.write_data))
      else $error("counter write not applied");

endmodule

/* hdl/dtc_rsp_buf.sv */
// two-entry response buffer: output register plus skid entry
module dtc_rsp_buf import dtc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_payload_type push_data,
   output logic            space,
   output logic            head_valid,
   input  logic            head_ready,
   output rsp_payload_type head_data
);

   logic            head_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type head_ff;
   rsp_payload_type skid_ff;
   logic            pop;

   assign pop        = head_valid_ff & head_ready;
   assign space      = ~skid_valid_ff;
   assign head_valid = head_valid_ff;
   assign head_data  = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else if (!push) begin
            head_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            head_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
         end else if (push) begin
            head_ff <= push_data;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_ff <= push_data;
         end else begin
            head_ff <= push_data;
         end
      end
   end

endmodule
